@@ rtl/fprf_pkg.sv @@
`timescale 1ns / 1ps
package fprf_pkg;

  localparam int FRAC_BITS_DEF    = 24;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b1;
  localparam int CFG_DATA_W = 31;

  localparam logic [7:0]  MAX_ITER_RST  = 8'd100;
  localparam logic [30:0] TOLERANCE_RST = 31'd1;

  localparam logic [1:0] OP_CUBIC_MINUS = 2'd0;
  localparam logic [1:0] OP_X_COS       = 2'd1;
  localparam logic [1:0] OP_CUBIC_PLUS  = 2'd2;
  localparam logic [1:0] OP_X_SIN       = 2'd3;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN  = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  localparam logic signed [63:0] WIDE_LIM    = 64'sd1 <<< 60;
  localparam logic signed [63:0] QUOT_LIM    = 64'sd1 <<< 40;
  localparam logic signed [63:0] TWO_PI_Q30  = 64'sd6746518852;
  localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
  localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;

  function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
    logic signed [63:0] v;
    begin
      case (i)
        5'd0: v = 64'sd843314857;
        5'd1: v = 64'sd497837829;
        5'd2: v = 64'sd263043837;
        5'd3: v = 64'sd133525159;
        5'd4: v = 64'sd67021687;
        5'd5: v = 64'sd33543516;
        5'd6: v = 64'sd16775851;
        5'd7: v = 64'sd8388437;
        5'd8: v = 64'sd4194283;
        5'd9: v = 64'sd2097149;
        default: v = 64'sd1 <<< (30 - i);
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    begin
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    end
  endfunction

  // datapath commands from the controller
  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_EVAL_P0, CMD_EVAL_P1, CMD_STEP, CMD_EVAL_P,
    CMD_UPDATE
  } fprf_cmd_t;

  typedef struct packed {
    logic busy;      // function unit or divider running
    logic den_zero;  // q1 == q0
    logic close;     // |p - p1| < tolerance
  } fprf_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EV0, S_W0, S_EV1, S_W1, S_CHK, S_DIV, S_WDIV, S_EVP, S_WP, S_TEST,
    S_OUT
  } fprf_state_t;

  // function unit states; *_H is the high-half cycle of a product
  typedef enum logic [3:0] {
    F_IDLE, F_SQ, F_SQ_H, F_CUBE, F_CUBE_H, F_MOD, F_RED, F_ROT, F_SIN, F_SIN_H,
    F_FIN
  } fprf_fstate_t;

endpackage

@@ rtl/fprf_if.sv @@
`timescale 1ns / 1ps
interface fprf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] interval_low;
  logic signed [31:0] interval_high;
  modport source (output valid, operation, interval_low, interval_high, input ready);
  modport sink   (input valid, operation, interval_low, interval_high, output ready);
endinterface

interface fprf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] root;
  logic signed [31:0] value_at_root;
  logic [7:0]         iterations;
  logic [1:0]         status;
  modport source (output valid, root, value_at_root, iterations, status, input ready);
  modport sink   (input valid, root, value_at_root, iterations, status, output ready);
endinterface

@@ rtl/false_position_root_finder.sv @@
`timescale 1ns / 1ps
// False-position root finder over four fixed functions, signed fixed point.
// in:  operation, interval_low, interval_high (valid/ready).
// out: root, value_at_root, iterations, status (valid/ready).
// cfg: cfg_we, cfg_index (0 max_iterations, 1 tolerance), cfg_wdata.
// One word is in flight at a time; in_ready is high only while idle.
// Work per word: two start evaluations, then per iteration one serial
// divide plus one function evaluation: two products on a 32x32 multiplier
// for the cubics; an angle reduction by 2*pi, the CORDIC rotations and one
// or two more steps for the trig functions.
// The result holds on the output until out_ready; no new word is taken
// until then. Reset (rst_n low, synchronous) returns to idle, drops any
// word in progress and restores max_iterations 100, tolerance 1.
module false_position_root_finder #(
  parameter int FRAC_BITS    = fprf_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = fprf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  fprf_in_if.sink                            in_ch,
  fprf_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [fprf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fprf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fprf_pkg::*;

  logic [7:0]  max_iter_r;
  logic [30:0] tol_r;
  fprf_cmd_t   cmd;
  fprf_stat_t  stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RST;
      tol_r <= TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_ITER:  max_iter_r <= cfg_wdata[7:0];
        CFG_TOLERANCE: tol_r <= cfg_wdata;
        default: tol_r <= tol_r;
      endcase
    end
  end

  fprf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .max_iterations(max_iter_r), .stat(stat), .cmd(cmd),
    .iterations(out_ch.iterations), .status(out_ch.status)
  );

  fprf_datapath #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .operation(in_ch.operation), .interval_low(in_ch.interval_low),
    .interval_high(in_ch.interval_high), .tolerance(tol_r), .stat(stat),
    .root(out_ch.root), .value_at_root(out_ch.value_at_root)
  );
endmodule

@@ rtl/fprf_func.sv @@
`timescale 1ns / 1ps
// Evaluates one of the four functions: each product is formed low half then
// high half on one 32x32 multiplier, the angle is reduced by 2*pi with one
// compare and subtract a cycle, and the CORDIC runs one step per cycle.
module fprf_func #(
  parameter int FRAC_BITS    = fprf_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = fprf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [1:0]                op,
  input  logic signed [31:0]        x,
  output logic                      busy,
  output logic                      done,
  output logic signed [31:0]        y
);
  import fprf_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam int NSTEP = (CORDIC_STEPS < 31) ? CORDIC_STEPS : 31;
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] C_0P2 = ((ONE_Q + 64'sd2) / 64'sd5);
  localparam logic signed [63:0] C_0P8 = ((ONE_Q * 64'sd4 + 64'sd2) / 64'sd5);

  fprf_fstate_t       st_r, st_nxt;
  logic [1:0]         op_r;
  logic signed [63:0] x_r, x2_r, a_r, cx_r, cy_r;
  logic               flip_r, neg_r;
  logic [4:0]         i_r;
  logic signed [31:0] y_r;
  logic               done_r;
  logic [63:0]        pp_r;

  // one 32x32 multiplier: low half of |ma| first, then high half
  logic signed [63:0] ma, mb, mres;
  logic [63:0]        mag_a, mag_b;
  logic               mul_hi;
  logic [31:0]        mul_x;
  logic [63:0]        pp;
  logic [95:0]        prod;
  logic [95:0]        pshift;
  logic [63:0]        mag;

  // |mb| always fits in 32 bits: x or the 0.2 constant
  always_comb begin
    mag_a = ma[63] ? 64'(-ma) : 64'(ma);
    mag_b = mb[63] ? 64'(-mb) : 64'(mb);
    mul_hi = (st_r == F_SQ_H) || (st_r == F_CUBE_H) || (st_r == F_SIN_H);
    mul_x = mul_hi ? mag_a[63:32] : mag_a[31:0];
    pp = {32'd0, mul_x} * {32'd0, mag_b[31:0]};
    prod = mul_hi ? (({32'd0, pp} << 32) + {32'd0, pp_r}) : {32'd0, pp};
    pshift = prod >> FRAC_BITS;
    if (prod[95:64] != 32'd0 || pshift > 96'(WIDE_LIM)) mag = 64'(WIDE_LIM);
    else mag = pshift[63:0];
    mres = (ma[63] != mb[63]) ? -$signed(mag) : $signed(mag);
  end

  always_comb begin
    ma = x_r;
    mb = x_r;
    case (st_r)
      F_CUBE, F_CUBE_H: begin ma = x2_r; mb = x_r; end
      F_SIN, F_SIN_H:   begin ma = $signed(cy_r) >>> SH; mb = C_0P2; end
      default: begin ma = x_r; mb = x_r; end
    endcase
  end

  logic signed [63:0] ang, mod_sub, a_mod, a_red;
  logic               flip_c;
  always_comb begin
    ang = 64'(x) <<< SH;
    mod_sub = TWO_PI_Q30 <<< i_r;
    // remainder keeps the sign of the angle
    a_mod = neg_r ? -a_r : a_r;
    if (a_mod > PI_Q30) a_mod = a_mod - TWO_PI_Q30;
    else if (a_mod < -PI_Q30) a_mod = a_mod + TWO_PI_Q30;
    flip_c = 1'b0;
    a_red = a_mod;
    if (a_mod > HALF_PI_Q30) begin a_red = PI_Q30 - a_mod; flip_c = 1'b1; end
    else if (a_mod < -HALF_PI_Q30) begin a_red = -PI_Q30 - a_mod; flip_c = 1'b1; end
  end

  logic signed [63:0] sx, sy, cosv;
  always_comb begin
    sx = cx_r >>> i_r;
    sy = cy_r >>> i_r;
    cosv = cx_r >>> SH;
    if (flip_r) cosv = -cosv;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE:   if (start) st_nxt = (op[0] == 1'b0) ? F_SQ : F_MOD;
      F_SQ:     st_nxt = F_SQ_H;
      F_SQ_H:   st_nxt = F_CUBE;
      F_CUBE:   st_nxt = F_CUBE_H;
      F_CUBE_H: st_nxt = F_IDLE;
      F_MOD:    if (i_r == 5'd0) st_nxt = F_RED;
      F_RED:    st_nxt = (NSTEP == 0) ? F_SIN : F_ROT;
      F_ROT:    if (32'(i_r) == NSTEP - 1) st_nxt = (op_r == OP_X_SIN) ? F_SIN : F_FIN;
      F_SIN:    st_nxt = F_SIN_H;
      F_SIN_H:  st_nxt = F_IDLE;
      F_FIN:    st_nxt = F_IDLE;
      default:  st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= (st_r == F_CUBE_H) || (st_r == F_SIN_H) || (st_r == F_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      F_IDLE: if (start) begin
        op_r  <= op;
        x_r   <= 64'(x);
        a_r   <= x[31] ? -ang : ang;
        neg_r <= x[31];
        i_r   <= 5'(SH);
      end
      F_SQ, F_CUBE, F_SIN: pp_r <= pp;
      F_SQ_H: x2_r <= mres;
      F_CUBE_H: begin
        if (op_r == OP_CUBIC_MINUS)
          y_r <= 32'(sat32(mres - 64'sd2 * x2_r - 64'sd5 * ONE_Q));
        else
          y_r <= 32'(sat32(mres + 64'sd3 * x2_r - ONE_Q));
      end
      // |angle| mod 2*pi, one multiple of 2*pi per cycle from the top
      F_MOD: begin
        if (a_r >= mod_sub) a_r <= a_r - mod_sub;
        i_r <= i_r - 5'd1;
      end
      F_RED: begin
        a_r <= a_red;
        flip_r <= flip_c;
        cx_r <= GAIN_Q30;
        cy_r <= 64'sd0;
        i_r <= 5'd0;
      end
      F_ROT: begin
        if (!a_r[63]) begin
          cx_r <= cx_r - sy;
          cy_r <= cy_r + sx;
          a_r  <= a_r - atan_q30(i_r);
        end else begin
          cx_r <= cx_r + sy;
          cy_r <= cy_r - sx;
          a_r  <= a_r + atan_q30(i_r);
        end
        i_r <= i_r + 5'd1;
      end
      F_SIN_H: y_r <= 32'(sat32(x_r - C_0P8 - mres));
      F_FIN: y_r <= 32'(sat32(x_r - cosv));
      default: ;
    endcase
  end

  assign busy = (st_r != F_IDLE);
  assign done = done_r;
  assign y = y_r;
endmodule

@@ rtl/fprf_div.sv @@
`timescale 1ns / 1ps
// Signed 64/64 restoring divider, one quotient bit per cycle, truncating.
module fprf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               busy,
  output logic               done,
  output logic signed [63:0] quot
);
  import fprf_pkg::*;

  logic        run_r, done_r, neg_r;
  logic [6:0]  cnt_r;
  logic [63:0] q_r, d_r;
  logic [64:0] rem_r;
  logic [64:0] trial;

  assign trial = {rem_r[63:0], q_r[63]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 7'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num[63] ? 64'(-num) : 64'(num);
      d_r <= den[63] ? 64'(-den) : 64'(den);
      rem_r <= 65'd0;
      neg_r <= num[63] ^ den[63];
    end else if (run_r) begin
      if (!trial[64]) begin
        rem_r <= trial;
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[63:0], q_r[63]};
        q_r <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

@@ rtl/fprf_datapath.sv @@
`timescale 1ns / 1ps
module fprf_datapath #(
  parameter int FRAC_BITS    = fprf_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = fprf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fprf_pkg::fprf_cmd_t     cmd,
  input  logic [1:0]              operation,
  input  logic signed [31:0]      interval_low,
  input  logic signed [31:0]      interval_high,
  input  logic [30:0]             tolerance,
  output fprf_pkg::fprf_stat_t    stat,
  output logic signed [31:0]      root,
  output logic signed [31:0]      value_at_root
);
  import fprf_pkg::*;

  logic [1:0]         op_r;
  logic signed [31:0] p0_r, p1_r, q0_r, q1_r, p_r, fp_r;
  logic               f_start, f_busy, f_done, d_start, d_busy, d_done;
  logic signed [31:0] fx, fy;
  logic signed [63:0] num, den, quot, qc, pn;

  assign f_start = (cmd == CMD_EVAL_P0) || (cmd == CMD_EVAL_P1) || (cmd == CMD_EVAL_P);
  assign fx = (cmd == CMD_EVAL_P0) ? p0_r : (cmd == CMD_EVAL_P1) ? p1_r : p_r;
  assign d_start = (cmd == CMD_STEP);
  assign num = 64'(q1_r) * 64'(p1_r - 64'(p0_r));
  assign den = 64'(q1_r) - 64'(q0_r);

  fprf_func #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_func (
    .clk(clk), .rst_n(rst_n), .start(f_start), .op(op_r), .x(fx),
    .busy(f_busy), .done(f_done), .y(fy)
  );

  fprf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .num(num), .den(den),
    .busy(d_busy), .done(d_done), .quot(quot)
  );

  logic [1:0] tgt_r;
  always_comb begin
    qc = quot;
    if (qc > QUOT_LIM) qc = QUOT_LIM;
    if (qc < -QUOT_LIM) qc = -QUOT_LIM;
    pn = sat32(64'(p1_r) - qc);
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) begin
      op_r <= operation;
      p0_r <= interval_low;
      p1_r <= interval_high;
      p_r <= 32'sd0;
      fp_r <= 32'sd0;
    end
    if (cmd == CMD_EVAL_P0) tgt_r <= 2'd0;
    if (cmd == CMD_EVAL_P1) tgt_r <= 2'd1;
    if (cmd == CMD_EVAL_P)  tgt_r <= 2'd2;
    if (f_done) begin
      case (tgt_r)
        2'd0: q0_r <= fy;
        2'd1: q1_r <= fy;
        default: fp_r <= fy;
      endcase
    end
    if (d_done) p_r <= 32'(pn);
    if (cmd == CMD_UPDATE) begin
      if (fp_r != 0 && q1_r != 0 && (fp_r[31] != q1_r[31])) begin
        p0_r <= p1_r;
        q0_r <= q1_r;
      end
      p1_r <= p_r;
      q1_r <= fp_r;
    end
  end

  logic signed [32:0] err;
  always_comb begin
    err = 33'(p_r) - 33'(p1_r);
    if (err[32]) err = -err;
  end

  assign stat.busy = f_busy | d_busy | f_start | d_start | f_done | d_done;
  assign stat.den_zero = (q1_r == q0_r);
  assign stat.close = (err < 33'(tolerance));
  assign root = p_r;
  assign value_at_root = fp_r;
endmodule

@@ rtl/fprf_ctrl.sv @@
`timescale 1ns / 1ps
module fprf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            max_iterations,
  input  fprf_pkg::fprf_stat_t  stat,
  output fprf_pkg::fprf_cmd_t   cmd,
  output logic [7:0]            iterations,
  output logic [1:0]            status
);
  import fprf_pkg::*;

  fprf_state_t st_r, st_nxt;
  logic [7:0]  it_r, it_nxt;
  logic [1:0]  status_r, status_nxt;

  always_comb begin
    st_nxt = st_r;
    it_nxt = it_r;
    status_nxt = status_r;
    case (st_r)
      S_IDLE: if (in_valid) begin
        st_nxt = S_EV0;
        it_nxt = 8'd2;
      end
      S_EV0: st_nxt = S_W0;
      S_W0:  if (!stat.busy) st_nxt = S_EV1;
      S_EV1: st_nxt = S_W1;
      S_W1:  if (!stat.busy) st_nxt = S_CHK;
      S_CHK: begin
        if (9'(it_r) > 9'(max_iterations)) begin
          status_nxt = ST_LIMIT;
          it_nxt = it_r - 8'd1;
          st_nxt = S_OUT;
        end else if (stat.den_zero) begin
          status_nxt = ST_ZERO_DEN;
          st_nxt = S_OUT;
        end else st_nxt = S_DIV;
      end
      S_DIV:  st_nxt = S_WDIV;
      S_WDIV: if (!stat.busy) st_nxt = S_EVP;
      S_EVP:  st_nxt = S_WP;
      S_WP:   if (!stat.busy) st_nxt = S_TEST;
      S_TEST: begin
        if (stat.close) begin
          status_nxt = ST_CONVERGED;
          st_nxt = S_OUT;
        end else if (it_r == 8'd255) begin
          // next number would pass any limit
          status_nxt = ST_LIMIT;
          st_nxt = S_OUT;
        end else begin
          it_nxt = it_r + 8'd1;
          st_nxt = S_CHK;
        end
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = CMD_NONE;
    case (st_r)
      S_IDLE: if (in_valid) cmd = CMD_LOAD;
      S_EV0:  cmd = CMD_EVAL_P0;
      S_EV1:  cmd = CMD_EVAL_P1;
      S_DIV:  cmd = CMD_STEP;
      S_EVP:  cmd = CMD_EVAL_P;
      S_TEST: if (!stat.close && it_r != 8'd255) cmd = CMD_UPDATE;
      default: cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      it_r <= 8'd0;
      status_r <= ST_LIMIT;
    end else begin
      st_r <= st_nxt;
      it_r <= it_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign iterations = it_r;
  assign status = status_r;
endmodule
